@@ rtl/core/scfp_pkg.sv @@
// ============================================================================
// scfp_pkg
// Shared types and constants for the serial command frame parser.
// ============================================================================
`default_nettype none

package scfp_pkg;

    localparam logic [7:0] HDR1_BYTE = 8'hAA;
    localparam logic [7:0] HDR2_BYTE = 8'h55;
    localparam logic [7:0] CMD_READ  = 8'h45;  // 'E'
    localparam logic [7:0] CMD_WRITE = 8'h4F;  // 'O'
    localparam logic [7:0] CMD_SPI   = 8'h53;  // 'S'
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] LF_BYTE   = 8'h0A;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_SPI   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HDR2    = 4'd1,
        PH_CMD     = 4'd2,
        PH_ADDR_HI = 4'd3,
        PH_ADDR_LO = 4'd4,
        PH_WVAL    = 4'd5,
        PH_SREG    = 4'd6,
        PH_DATA_HI = 4'd7,
        PH_DATA_LO = 4'd8,
        PH_CR      = 4'd9,
        PH_LF      = 4'd10
    } phase_t;

    // A byte handed from the input register to the decoder.
    typedef struct packed {
        logic       fire;
        logic [7:0] data;
    } byte_word_t;

    // One decoded command.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [15:0] payload;
    } result_t;

endpackage : scfp_pkg

`default_nettype wire

@@ rtl/core/serial_command_frame_parser.sv @@
// A command reaches out_valid from the result register, which loads it as the decoder takes its LF byte.
// Throughput: one byte per cycle; the input register and the frame decoder
// advance whenever the result register is empty or being emptied.
// Only the result register's stall reaches back to in_stall.
// Reset (rst_n low, asynchronous) returns the decoder to idle, clears the
// field accumulators and empties both registers.
// ============================================================================
// serial_command_frame_parser
// Recognizes header, command, fields and CR LF trailer in a byte stream and
// emits one decoded read, write or SPI command per complete frame.
// ============================================================================
`default_nettype none

module serial_command_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       command_kind,
    output logic [15:0]      target_address,
    output logic [15:0]      payload
);
    import scfp_pkg::*;

    byte_word_t word;
    logic       advance;
    logic       res_valid;
    result_t    res;

    scfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .word     (word)
    );

    scfp_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    scfp_out_stage u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res            (res),
        .can_take       (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .command_kind   (command_kind),
        .target_address (target_address),
        .payload        (payload)
    );

endmodule : serial_command_frame_parser

`default_nettype wire

@@ rtl/core/scfp_in_stage.sv @@
// ============================================================================
// scfp_in_stage
// Input register: holds one received byte until the decoder takes it.
// ============================================================================
`default_nettype none

module scfp_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               advance,
    output scfp_pkg::byte_word_t    word
);
    import scfp_pkg::*;

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       load;

    assign in_stall = vld_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign word.fire = vld_reg && advance;
    assign word.data = byte_reg;

endmodule : scfp_in_stage

`default_nettype wire

@@ rtl/core/scfp_decoder.sv @@
// ============================================================================
// scfp_decoder
// Frame state machine and field accumulators; one byte per cycle unless the output stalls.
// ============================================================================
`default_nettype none

module scfp_decoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scfp_pkg::byte_word_t word,
    output logic                      res_valid,
    output scfp_pkg::result_t         res
);
    import scfp_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    kind_t       kind_reg;
    kind_t       kind_next;
    logic [15:0] addr_reg;
    logic [15:0] addr_next;
    logic [15:0] pay_reg;
    logic [15:0] pay_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_READ;
            addr_reg  <= '0;
            pay_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            pay_reg   <= pay_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        pay_next    = pay_reg;
        res_valid   = 1'b0;
        res.kind    = kind_reg;
        res.addr    = addr_reg;
        res.payload = (kind_reg == KIND_READ) ? 16'd0 : pay_reg;

        if (word.fire)
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    // A repeated first header byte here still drops the frame.
                    phase_next = (word.data == HDR2_BYTE) ? PH_CMD : PH_IDLE;
                end
                PH_CMD:
                begin
                    addr_next = '0;
                    pay_next  = '0;
                    if (word.data == CMD_READ)
                    begin
                        kind_next  = KIND_READ;
                        phase_next = PH_ADDR_HI;
                    end
                    else if (word.data == CMD_WRITE)
                    begin
                        kind_next  = KIND_WRITE;
                        phase_next = PH_ADDR_HI;
                    end
                    else if (word.data == CMD_SPI)
                    begin
                        kind_next  = KIND_SPI;
                        phase_next = PH_SREG;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_ADDR_HI:
                begin
                    addr_next  = {word.data, 8'd0};
                    phase_next = PH_ADDR_LO;
                end
                PH_ADDR_LO:
                begin
                    addr_next  = {addr_reg[15:8], word.data};
                    phase_next = (kind_reg == KIND_WRITE) ? PH_WVAL : PH_CR;
                end
                PH_WVAL:
                begin
                    pay_next   = {8'd0, word.data};
                    phase_next = PH_CR;
                end
                PH_SREG:
                begin
                    addr_next  = {8'd0, word.data};
                    phase_next = PH_DATA_HI;
                end
                PH_DATA_HI:
                begin
                    pay_next   = {word.data, 8'd0};
                    phase_next = PH_DATA_LO;
                end
                PH_DATA_LO:
                begin
                    pay_next   = {pay_reg[15:8], word.data};
                    phase_next = PH_CR;
                end
                PH_CR:
                begin
                    phase_next = (word.data == CR_BYTE) ? PH_LF : PH_IDLE;
                end
                PH_LF:
                begin
                    res_valid  = (word.data == LF_BYTE);
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = (word.data == HDR1_BYTE) ? PH_HDR2 : PH_IDLE;
                end
            endcase
        end
    end

endmodule : scfp_decoder

`default_nettype wire

@@ rtl/core/scfp_out_stage.sv @@
// ============================================================================
// scfp_out_stage
// Result register: holds a decoded command until downstream takes it.
// ============================================================================
`default_nettype none

module scfp_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    input  wire scfp_pkg::result_t  res,
    output logic                    can_take,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              command_kind,
    output logic [15:0]             target_address,
    output logic [15:0]             payload
);
    import scfp_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    // The register is free when empty or when its word leaves this cycle.
    assign can_take = !vld_reg || !out_stall;

    always_comb
    begin
        if (can_take)
        begin
            vld_next = res_valid;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = vld_reg;
    assign command_kind   = res_reg.kind;
    assign target_address = res_reg.addr;
    assign payload        = res_reg.payload;

endmodule : scfp_out_stage

`default_nettype wire

@@ rtl/core/scfp_checker.sv @@
// ============================================================================
// scfp_checker
// Port-level checks on the frame parser, attached by bind.
// ============================================================================
`default_nettype none

module scfp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  command_kind,
    input wire logic [15:0] target_address,
    input wire logic [15:0] payload
);
    import scfp_pkg::*;

    // Input only backs up when a finished word is stuck at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked output word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(command_kind)
            && $stable(target_address) && $stable(payload)))
        else $error("stalled output word changed");

    a_read_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && command_kind == KIND_READ) |-> (payload == 16'd0))
        else $error("memory read carries nonzero payload");

    a_write_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && command_kind == KIND_WRITE) |-> (payload[15:8] == 8'd0))
        else $error("memory write payload wider than one byte");

    a_spi_reg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((command_kind == KIND_READ || command_kind == KIND_WRITE)
            || (command_kind == KIND_SPI && target_address[15:8] == 8'd0)))
        else $error("bad command kind or SPI register out of range");

endmodule : scfp_checker

bind serial_command_frame_parser scfp_checker u_scfp_checker (.*);

`default_nettype wire
